/* rtl/arenv_pkg.sv */
`timescale 1ns / 1ps

package arenv_pkg;

  // Field widths of the channels.
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned SEG_W   = 2;

  // Number of quotient bits, one per divider stage.
  localparam int unsigned QUO_W = 16;

  // Q1.15 full scale.
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

  // Segment codes as they appear on the result channel.
  typedef enum logic [SEG_W-1:0] {
    SEG_OUTSIDE = 2'd0,
    SEG_RISE    = 2'd1,
    SEG_FULL    = 2'd2,
    SEG_FALL    = 2'd3
  } seg_t;

  // How the final level is formed at the end of the pipeline.
  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_FULL = 2'd1,
    LVL_QUOT = 2'd2
  } lvl_kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ATTACK_START  = 2'd0,
    REG_SUSTAIN_START = 2'd1,
    REG_DECAY_START   = 2'd2,
    REG_RELEASE_END   = 2'd3
  } cfg_reg_t;

  // Current envelope breakpoints.
  typedef struct packed {
    logic [TICK_W-1:0] attack_start;
    logic [TICK_W-1:0] sustain_start;
    logic [TICK_W-1:0] decay_start;
    logic [TICK_W-1:0] release_end;
  } cfg_t;

  // Content of one divider pipeline stage.
  typedef struct packed {
    logic              valid;
    seg_t              seg;
    lvl_kind_t         kind;
    logic [TICK_W:0]   r2;
    logic [TICK_W-1:0] den;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

endpackage

/* rtl/arenv_in_if.sv */
`timescale 1ns / 1ps

interface arenv_in_if
  import arenv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] time_tick;

  modport source (output valid, output time_tick, input ready);
  modport sink (input valid, input time_tick, output ready);
endinterface

/* rtl/arenv_out_if.sv */
`timescale 1ns / 1ps

interface arenv_out_if
  import arenv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [SEG_W-1:0]   segment;

  modport source (output valid, output level, output segment, input ready);
  modport sink (input valid, input level, input segment, output ready);
endinterface

/* rtl/arenv_cfg_if.sv */
`timescale 1ns / 1ps

interface arenv_cfg_if
  import arenv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [TICK_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/arenv_front.sv */
`timescale 1ns / 1ps

module arenv_front
  import arenv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [TICK_W-1:0] tick,
  input  cfg_t              cfg,
  output div_stage_t        d_out
);

  div_stage_t d_r;
  div_stage_t d_nxt;

  logic below_attack;
  logic above_release;
  logic below_sustain;
  logic below_decay;
  logic rise_flat;
  logic fall_flat;
  logic [TICK_W-1:0] rise_num;
  logic [TICK_W-1:0] rise_den;
  logic [TICK_W-1:0] fall_num;
  logic [TICK_W-1:0] fall_den;

  // All compares and differences are formed side by side.
  always_comb begin
    below_attack  = tick < cfg.attack_start;
    above_release = tick > cfg.release_end;
    below_sustain = tick < cfg.sustain_start;
    below_decay   = tick < cfg.decay_start;
    rise_flat     = cfg.sustain_start == cfg.attack_start;
    fall_flat     = cfg.release_end == cfg.decay_start;
    rise_num      = tick - cfg.attack_start;
    rise_den      = cfg.sustain_start - cfg.attack_start;
    fall_num      = cfg.release_end - tick;
    fall_den      = cfg.release_end - cfg.decay_start;
  end

  // Pick the segment and load the divider with numerator and divisor.
  // The numerator never exceeds the divisor, so it starts the division directly.
  always_comb begin
    d_nxt       = '0;
    d_nxt.valid = in_valid;
    d_nxt.quo   = '0;
    if (below_attack || above_release) begin
      d_nxt.seg  = SEG_OUTSIDE;
      d_nxt.kind = LVL_ZERO;
    end else if (below_sustain) begin
      d_nxt.seg  = SEG_RISE;
      d_nxt.kind = rise_flat ? LVL_ZERO : LVL_QUOT;
      d_nxt.r2   = {1'b0, rise_num};
      d_nxt.den  = rise_den;
    end else if (below_decay) begin
      d_nxt.seg  = SEG_FULL;
      d_nxt.kind = LVL_FULL;
    end else begin
      // A zero-length release gives zero instead of a 0/0 quotient.
      d_nxt.seg  = SEG_FALL;
      d_nxt.kind = fall_flat ? LVL_ZERO : LVL_QUOT;
      d_nxt.r2   = {1'b0, fall_num};
      d_nxt.den  = fall_den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* rtl/arenv_div_step.sv */
`timescale 1ns / 1ps

module arenv_div_step
  import arenv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  div_stage_t d_in,
  output div_stage_t d_out
);

  div_stage_t d_r;
  div_stage_t d_nxt;

  logic              fits;
  logic [TICK_W:0]   diff;
  logic [TICK_W-1:0] rem;

  // One restoring step: subtract the divisor if it fits, then double.
  always_comb begin
    fits      = d_in.r2 >= {1'b0, d_in.den};
    diff      = d_in.r2 - {1'b0, d_in.den};
    rem       = fits ? diff[TICK_W-1:0] : d_in.r2[TICK_W-1:0];
    d_nxt     = d_in;
    d_nxt.r2  = {rem, 1'b0};
    d_nxt.quo = {d_in.quo[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* rtl/linear_attack_release_envelope.sv */
`timescale 1ns / 1ps

// Linear attack-hold-release envelope evaluator.
// in_ch carries one time tick per transfer; out_ch returns one result per
// tick, in order: the Q1.15 level (32768 is one) and the segment code
// (0 outside, 1 rising, 2 full, 3 falling).
// cfg_ch writes the four breakpoints, index 0 to 3: attack start, sustain
// start, decay start, release end. It is always ready; write only while
// no result is outstanding.
// An input tick passes through one classify stage, sixteen divider stages
// (one quotient bit each, a 33-bit compare and subtract per stage) and the
// output register. Throughput is one tick per cycle while out_ch does not
// stall. All stages advance together whenever the output register is empty
// or being taken, so in_ch.ready drops only while out_ch stalls with a
// result held; nothing is lost or repeated.
// Reset clears every valid bit and sets all breakpoints to zero.

module linear_attack_release_envelope
  import arenv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  arenv_in_if.sink    in_ch,
  arenv_out_if.source out_ch,
  arenv_cfg_if.sink   cfg_ch
);

  cfg_t       cfg_r;
  div_stage_t stg [QUO_W+1];

  logic               adv;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [SEG_W-1:0]   out_segment_r;
  logic [LEVEL_W-1:0] level_nxt;
  div_stage_t         last;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ATTACK_START:  cfg_r.attack_start  <= cfg_ch.data;
        REG_SUSTAIN_START: cfg_r.sustain_start <= cfg_ch.data;
        REG_DECAY_START:   cfg_r.decay_start   <= cfg_ch.data;
        REG_RELEASE_END:   cfg_r.release_end   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a result.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  arenv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .tick     (in_ch.time_tick),
    .cfg      (cfg_r),
    .d_out    (stg[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    arenv_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (stg[g]),
      .d_out (stg[g+1])
    );
  end

  assign last = stg[QUO_W];

  // Final level selection with a clamp to full scale.
  always_comb begin
    case (last.kind)
      LVL_ZERO: level_nxt = '0;
      LVL_FULL: level_nxt = FULL_SCALE;
      LVL_QUOT: level_nxt = (last.quo > FULL_SCALE) ? FULL_SCALE : last.quo;
      default:  level_nxt = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r   <= level_nxt;
      out_segment_r <= last.seg;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.level   = out_level_r;
  assign out_ch.segment = out_segment_r;

  // An accepted tick always lands in the classify stage.
  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> stg[0].valid)
    else $error("accepted tick missing from classify stage");

  // Outside the envelope the level is zero.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.segment == SEG_OUTSIDE) |-> (out_ch.level == '0))
    else $error("nonzero level outside the envelope");

  // The hold segment always reports full scale.
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.segment == SEG_FULL) |-> (out_ch.level == FULL_SCALE))
    else $error("hold segment not at full scale");

  // The level never exceeds full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.level <= FULL_SCALE))
    else $error("level above full scale");

  // A stall freezes the last divider stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(last))
    else $error("divider moved during a stall");

endmodule

/* verif/tb_linear_attack_release_envelope.sv */
`timescale 1ns / 1ps

module tb_linear_attack_release_envelope
  import arenv_pkg::*;
;

  localparam int unsigned LATENCY   = 18;
  localparam int unsigned MAX_SHOWN = 10;

  // One envelope sample as it leaves the result channel.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    seg_t               segment;
  } env_point_t;

  logic clk;
  logic rst_n;

  arenv_in_if  in_if ();
  arenv_out_if out_if ();
  arenv_cfg_if cfg_if ();

  linear_attack_release_envelope dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Breakpoints as the block should currently hold them.
  cfg_t env_cfg;

  // Envelope points still owed by the block, oldest first.
  env_point_t pending_points[$];

  int unsigned ticks_sent;
  int unsigned points_checked;
  int unsigned cfg_writes;
  int unsigned envelopes_loaded;
  int unsigned mismatches;
  int unsigned failures;
  bit          bursts_on;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout after %0d ticks and %0d checked points", ticks_sent, points_checked);
    $display("Test completed with failures");
    $finish;
  end

  // Truncated Q1.15 fraction num/den, clamped to full scale.
  function automatic logic [LEVEL_W-1:0] ramp_fraction(input logic [TICK_W-1:0] num,
                                                       input logic [TICK_W-1:0] den);
    logic [63:0] quo;
    if (den == '0) return '0;
    quo = {17'd0, num, 15'd0} / {32'd0, den};
    if (quo > 64'(FULL_SCALE)) quo = 64'(FULL_SCALE);
    return quo[LEVEL_W-1:0];
  endfunction

  // Envelope level and segment at one tick under the current breakpoints.
  function automatic env_point_t envelope_at(input logic [TICK_W-1:0] t);
    env_point_t p;
    if (t < env_cfg.attack_start || t > env_cfg.release_end) begin
      p.level   = '0;
      p.segment = SEG_OUTSIDE;
    end else if (t < env_cfg.sustain_start) begin
      p.level   = ramp_fraction(t - env_cfg.attack_start,
                                env_cfg.sustain_start - env_cfg.attack_start);
      p.segment = SEG_RISE;
    end else if (t < env_cfg.decay_start) begin
      p.level   = FULL_SCALE;
      p.segment = SEG_FULL;
    end else begin
      // A zero-length release lands here with a zero denominator.
      p.level   = ramp_fraction(env_cfg.release_end - t,
                                env_cfg.release_end - env_cfg.decay_start);
      p.segment = SEG_FALL;
    end
    return p;
  endfunction

  // Ticks cluster around the breakpoints, with some spread over the whole range.
  function automatic logic [TICK_W-1:0] pick_tick();
    logic [TICK_W-1:0] base;
    case ($urandom_range(0, 6))
      0: base = env_cfg.attack_start;
      1: base = env_cfg.sustain_start;
      2: base = env_cfg.decay_start;
      3: base = env_cfg.release_end;
      4: begin
        if (env_cfg.release_end > env_cfg.attack_start)
          return env_cfg.attack_start +
                 $urandom_range(0, env_cfg.release_end - env_cfg.attack_start);
        return $urandom();
      end
      default: return $urandom();
    endcase
    return base + $urandom_range(0, 8) - 4;
  endfunction

  // Segment length: often zero, mostly short.
  function automatic logic [TICK_W-1:0] seg_len();
    if ($urandom_range(0, 4) == 0) return '0;
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(1, 300);
  endfunction

  // Receiver side: random stalls in bursts while enabled.
  initial begin : out_stall
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      // A burst in progress ends as soon as idling is switched off.
      if (!bursts_on)
        stall_left = 0;
      if (stall_left == 0 && bursts_on && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest predicted point.
  always @(posedge clk) begin : result_check
    env_point_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_points.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected result: level %0d segment %0d", out_if.level, out_if.segment);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (out_if.level !== want.level || out_if.segment !== want.segment) begin
          failures++;
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display({"Mismatch at point %0d: expected level %0d segment %0d, ",
                      "got level %0d segment %0d"},
                     points_checked, want.level, want.segment, out_if.level, out_if.segment);
        end
      end
    end
  end

  // Send one tick, with an optional gap first, and record its envelope point.
  task automatic send_tick(input logic [TICK_W-1:0] t);
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.time_tick <= t;
    do @(posedge clk); while (!in_if.ready);
    pending_points.push_back(envelope_at(t));
    ticks_sent++;
  endtask

  // Write one breakpoint register; the caller lowers valid afterwards.
  task automatic write_reg(input cfg_reg_t idx, input logic [TICK_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_ATTACK_START:  env_cfg.attack_start  = value;
      REG_SUSTAIN_START: env_cfg.sustain_start = value;
      REG_DECAY_START:   env_cfg.decay_start   = value;
      REG_RELEASE_END:   env_cfg.release_end   = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Load all four breakpoints; only called with the pipeline empty.
  task automatic load_envelope(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] s,
                               input logic [TICK_W-1:0] d, input logic [TICK_W-1:0] r);
    write_reg(REG_ATTACK_START, a);
    write_reg(REG_SUSTAIN_START, s);
    write_reg(REG_DECAY_START, d);
    write_reg(REG_RELEASE_END, r);
    cfg_if.valid <= 1'b0;
    envelopes_loaded++;
  endtask

  // Stop sending and wait until every predicted point has come back.
  task automatic settle_pipeline();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_points.size() != 0);
    @(posedge clk);
  endtask

  // After reset every breakpoint is zero: tick zero is a zero-length release.
  task automatic test_reset_state();
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'hFFFF_FFFF);
    settle_pipeline();
  endtask

  // Both ramps and the hold of an ordered envelope, at and around each edge.
  task automatic test_ordered_ramps();
    logic [TICK_W-1:0] ticks [11];
    ticks = '{32'd99, 32'd100, 32'd150, 32'd199, 32'd200, 32'd299,
              32'd300, 32'd301, 32'd399, 32'd400, 32'd401};
    load_envelope(32'd100, 32'd200, 32'd300, 32'd400);
    foreach (ticks[i]) send_tick(ticks[i]);
    settle_pipeline();
  endtask

  // Breakpoints at the ends of the tick range, including the widest ramps.
  task automatic test_full_range();
    load_envelope(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(32'd0);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'hFFFF_FFFE);
    send_tick(32'hFFFF_FFFF);
    settle_pipeline();
    load_envelope(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
    settle_pipeline();
  endtask

  // Decay start equal to release end: the end tick falls with level zero.
  task automatic test_zero_release();
    load_envelope(32'd10, 32'd20, 32'd30, 32'd30);
    send_tick(32'd29);
    send_tick(32'd30);
    send_tick(32'd31);
    settle_pipeline();
  endtask

  // Breakpoints out of order: these ticks land outside or in the falling segment.
  task automatic test_unordered();
    load_envelope(32'd500, 32'd100, 32'd50, 32'd1000);
    send_tick(32'd75);
    send_tick(32'd500);
    send_tick(32'd1000);
    settle_pipeline();
  endtask

  // Random ordered envelopes, some phases with idling and some without.
  task automatic test_random_ordered(input int unsigned n_phases, input int unsigned n_ticks);
    logic [TICK_W-1:0] a, s, d;
    repeat (n_phases) begin
      a = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 900) : $urandom();
      s = a + seg_len();
      d = s + seg_len();
      load_envelope(a, s, d, d + seg_len());
      bursts_on = ($urandom_range(0, 3) != 0);
      repeat (n_ticks) send_tick(pick_tick());
      settle_pipeline();
    end
  endtask

  // Breakpoints close together but in random order.
  task automatic test_random_unordered(input int unsigned n_phases, input int unsigned n_ticks);
    logic [TICK_W-1:0] base;
    repeat (n_phases) begin
      base = $urandom();
      load_envelope(base + $urandom_range(0, 400), base + $urandom_range(0, 400),
                    base + $urandom_range(0, 400), base + $urandom_range(0, 400));
      bursts_on = 1'b1;
      repeat (n_ticks) send_tick(pick_tick());
      settle_pipeline();
    end
  endtask

  // Full-rate transfers on both sides with no idling at all.
  task automatic test_back_to_back(input int unsigned n_ticks);
    bursts_on = 1'b0;
    test_random_ordered(1, 0);
    bursts_on = 1'b0;
    repeat (n_ticks) send_tick(pick_tick());
    settle_pipeline();
  endtask

  // Main sequence.
  initial begin
    ticks_sent       = 0;
    points_checked   = 0;
    cfg_writes       = 0;
    envelopes_loaded = 0;
    mismatches       = 0;
    failures         = 0;
    bursts_on        = 1'b0;
    env_cfg          = '0;

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.time_tick <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_ATTACK_START;
    cfg_if.data     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_ordered_ramps();
    test_full_range();
    test_zero_release();
    test_unordered();
    test_random_ordered(11, 100);
    test_random_unordered(4, 100);
    test_back_to_back(200);

    // Let any stray result show up before closing.
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_points.size() != 0) begin
      failures += pending_points.size();
      $display("%0d envelope points never arrived", pending_points.size());
    end

    $display("Sent %0d ticks over %0d breakpoint sets (%0d register writes).",
             ticks_sent, envelopes_loaded, cfg_writes);
    $display("Checked %0d envelope points, %0d of them wrong or unexpected.",
             points_checked, mismatches);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
